// File: rtl/core/pwt_pkg.sv
// Package: constants, types and command/status structs for the waypoint tracker.
package pwt_pkg;

  localparam int unsigned MaxPoints     = 1024;
  localparam int unsigned IdxW          = $clog2(MaxPoints);
  localparam int unsigned CntW          = IdxW + 1;
  localparam int unsigned BackWindow    = 10;
  localparam int unsigned ForwardWindow = 30;
  localparam int unsigned BaseLookahead = 5120;
  localparam int unsigned CoordW        = 32;
  localparam int unsigned CurvW         = 15;
  localparam int unsigned SpeedW        = 16;
  localparam int unsigned DistW         = 27;
  localparam int unsigned SqW           = 65;

  typedef enum logic [2:0] {
    CFG_POINT_COUNT      = 3'd0,
    CFG_LOOKAHEAD_GAIN   = 3'd1,
    CFG_CURVATURE_WINDOW = 3'd2,
    CFG_CURVE_THRESHOLD  = 3'd3,
    CFG_CURVE_SPEED      = 3'd4,
    CFG_CRUISE_SPEED     = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Which scan a table read belongs to.
  typedef enum logic [1:0] {
    SCAN_CLOSE = 2'd0,
    SCAN_TGT   = 2'd1,
    SCAN_CURV  = 2'd2
  } scan_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CLOSE,
    ST_TGT_INIT,
    ST_TARGET,
    ST_CURV_INIT,
    ST_CURV,
    ST_DRAIN,
    ST_OUT
  } state_e;

  // Per-item command from controller to datapath.
  typedef struct packed {
    logic capture;    // latch request fields
    logic write_tab;  // write a waypoint into the table
    logic setup;      // compute window bounds and lookahead
    logic scan_close; // issue a closest-search read
    logic tgt_init;   // start target scan
    logic scan_tgt;   // issue a target-scan read
    logic curv_init;  // start curvature scan
    logic scan_curv;  // issue a curvature read
    logic finish;     // load result register
  } cmd_t;

  typedef struct packed {
    logic close_done; // last closest read issued
    logic tgt_done;   // target found or table ended
    logic curv_done;  // last curvature read issued
    logic pipe_empty; // no read in flight
  } status_t;

endpackage

// File: rtl/core/pwt_ram.sv
// Generic single-port RAM with registered read.
module pwt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/core/pwt_ctrl.sv
// Controller state machine sequencing loads and the three query scans.
module pwt_ctrl import pwt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_op_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          cmd_o.capture = 1'b1;
          if (in_op_i == OP_QUERY) begin
            state_d = ST_SETUP;
          end else begin
            cmd_o.write_tab = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_CLOSE;
      end
      ST_CLOSE: begin
        if (status_i.close_done) begin
          state_d = ST_TGT_INIT;
        end else begin
          cmd_o.scan_close = 1'b1;
        end
      end
      ST_TGT_INIT: begin
        if (status_i.pipe_empty) begin
          cmd_o.tgt_init = 1'b1;
          state_d        = ST_TARGET;
        end
      end
      ST_TARGET: begin
        if (status_i.tgt_done) begin
          if (status_i.pipe_empty) begin
            state_d = ST_CURV_INIT;
          end
        end else begin
          cmd_o.scan_tgt = 1'b1;
        end
      end
      ST_CURV_INIT: begin
        cmd_o.curv_init = 1'b1;
        state_d         = ST_CURV;
      end
      ST_CURV: begin
        if (status_i.curv_done) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.scan_curv = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finish did not raise result valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("request taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.scan_close, cmd_o.scan_tgt, cmd_o.scan_curv}) <= 1)
    else $error("two scans issued at once");
endmodule

// File: rtl/core/pwt_dp.sv
// Datapath: waypoint tables, scan counters, distance pipeline and result register.
module pwt_dp import pwt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  input  logic [IdxW-1:0]          point_index_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic [CurvW-1:0]         point_curvature_i,
  input  logic [SpeedW-1:0]        ego_speed_i,
  input  logic [CntW-1:0]          point_count_i,
  input  logic [SpeedW-1:0]        lookahead_gain_i,
  input  logic [CntW-1:0]          curvature_window_i,
  input  logic [CurvW-1:0]         curve_threshold_i,
  input  logic [SpeedW-1:0]        curve_speed_i,
  input  logic [SpeedW-1:0]        cruise_speed_i,
  output logic [IdxW-1:0]          close_index_o,
  output logic [IdxW-1:0]          target_index_o,
  output logic [DistW-1:0]         lookahead_distance_o,
  output logic [CurvW-1:0]         max_curvature_o,
  output logic [SpeedW-1:0]        target_speed_o
);
  // Request capture.
  logic [IdxW-1:0]          pidx_q;
  logic signed [CoordW-1:0] px_q, py_q;
  logic [CurvW-1:0]         pk_q;
  logic [SpeedW-1:0]        spd_q;
  logic                     wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
    end else begin
      wr_q <= cmd_i.write_tab;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pidx_q <= point_index_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pk_q   <= point_curvature_i;
      spd_q  <= ego_speed_i;
    end
  end

  // Setup: effective count, window bounds, lookahead.
  logic [CntW-1:0]  n_q;
  logic [CntW-1:0]  n_eff;
  logic [IdxW-1:0]  last_q;
  logic [CntW-1:0]  cend_q;    // exclusive end of closest window
  logic [DistW-1:0] ld_q;
  logic [53:0]      ld2_q;
  logic [2*DistW-1:0] ld2_full;
  logic [CntW:0]    fwd_end;
  logic [31:0]      gprod;

  always_comb begin
    n_eff = point_count_i;
    if (n_eff == '0) begin
      n_eff = CntW'(1);
    end else if (n_eff > CntW'(MaxPoints)) begin
      n_eff = CntW'(MaxPoints);
    end
  end

  assign gprod    = {16'd0, lookahead_gain_i} * {16'd0, spd_q};
  assign fwd_end  = (CntW+1)'(last_q) + (CntW+1)'(ForwardWindow + 1);
  assign ld2_full = {{DistW{1'b0}}, ld_q} * {{DistW{1'b0}}, ld_q};

  // Scan address and pipeline.
  logic [CntW-1:0] addr_q;
  logic [CntW-1:0] tend_q;
  logic            tgt_hit_q;
  logic [CntW-1:0] curv_end_q;
  logic [2:0]      v_q;   // read in flight, per pipeline stage
  scan_e           kind_q [3];
  logic [IdxW-1:0] pidx_s [3];
  logic            issue;
  scan_e           issue_kind;
  logic [IdxW-1:0] ram_addr;
  logic            we;

  assign we    = wr_q;
  assign issue = cmd_i.scan_close || cmd_i.scan_tgt || cmd_i.scan_curv;
  assign issue_kind = cmd_i.scan_close ? SCAN_CLOSE : (cmd_i.scan_tgt ? SCAN_TGT : SCAN_CURV);
  assign ram_addr = we ? pidx_q : addr_q[IdxW-1:0];

  logic [CoordW-1:0] rx, ry;
  logic [CurvW-1:0]  rk;

  pwt_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_x (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(px_q), .rdata_o(rx));
  pwt_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_y (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(py_q), .rdata_o(ry));
  pwt_ram #(.Width(CurvW), .Depth(MaxPoints)) u_ram_k (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(pk_q), .rdata_o(rk));

  // Stage 1: absolute differences; stage 2: squares; stage 3: sum and compare.
  logic [CoordW:0]   dx_q, dy_q;
  logic [2*CoordW+1:0] sx_q, sy_q;
  logic [SqW-1:0]    best_q, dsum;
  logic              best_none_q;
  logic [IdxW-1:0]   close_q, target_q;
  logic [CurvW-1:0]  maxk_q;
  logic signed [CoordW:0] ex, ey;

  assign ex   = $signed({rx[CoordW-1], rx}) - $signed({px_q[CoordW-1], px_q});
  assign ey   = $signed({ry[CoordW-1], ry}) - $signed({py_q[CoordW-1], py_q});
  assign dsum = SqW'(sx_q) + SqW'(sy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      last_q <= '0;
    end else begin
      v_q <= {v_q[1:0], issue};
      if (cmd_i.finish) begin
        last_q <= close_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q[0] <= issue_kind;
    kind_q[1] <= kind_q[0];
    kind_q[2] <= kind_q[1];
    pidx_s[0] <= addr_q[IdxW-1:0];
    pidx_s[1] <= pidx_s[0];
    pidx_s[2] <= pidx_s[1];
    dx_q <= ex[CoordW] ? (CoordW+1)'(-ex) : (CoordW+1)'(ex);
    dy_q <= ey[CoordW] ? (CoordW+1)'(-ey) : (CoordW+1)'(ey);
    sx_q <= (2*CoordW+2)'(dx_q) * (2*CoordW+2)'(dx_q);
    sy_q <= (2*CoordW+2)'(dy_q) * (2*CoordW+2)'(dy_q);
    if (cmd_i.setup) begin
      n_q    <= n_eff;
      ld_q   <= DistW'(BaseLookahead) + DistW'(gprod >> 6);
      addr_q <= (last_q >= IdxW'(BackWindow)) ? CntW'(last_q - IdxW'(BackWindow)) : '0;
      cend_q <= (fwd_end > (CntW+1)'(n_eff)) ? n_eff : CntW'(fwd_end);
      close_q     <= last_q;
      best_none_q <= 1'b1;
    end
    ld2_q <= ld2_full[53:0];
    if (issue) begin
      addr_q <= addr_q + CntW'(1);
    end
    if (cmd_i.tgt_init) begin
      addr_q    <= CntW'(close_q);
      tend_q    <= n_q;
      target_q  <= close_q;
      tgt_hit_q <= 1'b0;
    end
    if (cmd_i.curv_init) begin
      addr_q     <= CntW'(close_q);
      curv_end_q <= ((CntW+1)'(close_q) + (CntW+1)'(curvature_window_i) > (CntW+1)'(n_q))
                    ? n_q : CntW'(CntW'(close_q) + curvature_window_i);
      maxk_q     <= '0;
    end
    if (v_q[2]) begin
      case (kind_q[2])
        SCAN_CLOSE: begin
          if (best_none_q || dsum < best_q) begin
            best_q      <= dsum;
            best_none_q <= 1'b0;
            close_q     <= pidx_s[2];
          end
        end
        SCAN_TGT: begin
          if (!tgt_hit_q && dsum > SqW'(ld2_q)) begin
            tgt_hit_q <= 1'b1;
            target_q  <= pidx_s[2];
          end
        end
        default: ;
      endcase
    end
    // Curvature read is only one stage deep.
    if (v_q[0] && kind_q[0] == SCAN_CURV && rk > maxk_q) begin
      maxk_q <= rk;
    end
    if (cmd_i.finish) begin
      close_index_o        <= close_q;
      target_index_o       <= target_q;
      lookahead_distance_o <= ld_q;
      max_curvature_o      <= maxk_q;
      target_speed_o       <= (maxk_q > curve_threshold_i) ? curve_speed_i : cruise_speed_i;
    end
  end

  assign status_o.close_done = (addr_q >= cend_q);
  assign status_o.tgt_done   = tgt_hit_q || (addr_q >= tend_q);
  assign status_o.curv_done  = (addr_q >= curv_end_q);
  assign status_o.pipe_empty = (v_q == '0) && !issue;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> v_q == '0)
    else $error("result taken with reads in flight");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> !we)
    else $error("table write collides with scan read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> last_q == close_index_o)
    else $error("saved closest index differs from result");
endmodule

// File: rtl/core/path_waypoint_tracker_core.sv
// Top level: config registers, controller and datapath of the waypoint tracker.
// Load request: taken while idle, table write in the following cycle; no result.
// Query request: closest-point scan over a window of at most 41 points, then target scan,
//   then curvature scan over the curvature window; one table read per cycle while a scan runs.
// One request in flight; the next is taken once the result sits in the output register.
// Async active-low reset: config to defaults, saved closest index to 0; tables unset.
module path_waypoint_tracker_core import pwt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     operation_i,
  input  logic [IdxW-1:0]          point_index_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic [CurvW-1:0]         point_curvature_i,
  input  logic [SpeedW-1:0]        ego_speed_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IdxW-1:0]          close_index_o,
  output logic [IdxW-1:0]          target_index_o,
  output logic [DistW-1:0]         lookahead_distance_o,
  output logic [CurvW-1:0]         max_curvature_o,
  output logic [SpeedW-1:0]        target_speed_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [2:0]               cfg_index_i,
  input  logic [SpeedW-1:0]        cfg_data_i
);
  // Configuration registers; writes are always taken.
  logic [CntW-1:0]   point_count_q;
  logic [SpeedW-1:0] lookahead_gain_q;
  logic [CntW-1:0]   curvature_window_q;
  logic [CurvW-1:0]  curve_threshold_q;
  logic [SpeedW-1:0] curve_speed_q;
  logic [SpeedW-1:0] cruise_speed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q      <= CntW'(1);
      lookahead_gain_q   <= SpeedW'(256);
      curvature_window_q <= CntW'(20);
      curve_threshold_q  <= CurvW'(410);
      curve_speed_q      <= '0;
      cruise_speed_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POINT_COUNT:      point_count_q      <= cfg_data_i[CntW-1:0];
        CFG_LOOKAHEAD_GAIN:   lookahead_gain_q   <= cfg_data_i;
        CFG_CURVATURE_WINDOW: curvature_window_q <= cfg_data_i[CntW-1:0];
        CFG_CURVE_THRESHOLD:  curve_threshold_q  <= cfg_data_i[CurvW-1:0];
        CFG_CURVE_SPEED:      curve_speed_q      <= cfg_data_i;
        CFG_CRUISE_SPEED:     cruise_speed_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cmd_t    cmd;
  status_t status;

  pwt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_op_i(operation_i), .in_stall_o,
    .out_valid_o, .out_stall_i, .status_i(status), .cmd_o(cmd));

  pwt_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .point_index_i, .pos_x_i, .pos_y_i, .point_curvature_i, .ego_speed_i,
    .point_count_i(point_count_q), .lookahead_gain_i(lookahead_gain_q),
    .curvature_window_i(curvature_window_q), .curve_threshold_i(curve_threshold_q),
    .curve_speed_i(curve_speed_q), .cruise_speed_i(cruise_speed_q),
    .close_index_o, .target_index_o, .lookahead_distance_o,
    .max_curvature_o, .target_speed_o);
endmodule
